[sv/rstoi_pkg.sv]
//------------------------------------------------------------------------------
// rstoi_pkg
// Types, character codes and decode helpers for the radix string-to-integer
// parser.
//------------------------------------------------------------------------------
`default_nettype none

package rstoi_pkg;

   localparam int VALUE_W     = 40;
   localparam int ACC_W       = VALUE_W + 1;
   localparam int TWOS_DIGITS = 10;

   localparam logic [1:0] RADIX_BIN   = 2'd0;
   localparam logic [1:0] RADIX_OCT   = 2'd1;
   localparam logic [1:0] RADIX_HEX   = 2'd2;
   localparam logic [1:0] RADIX_RESET = RADIX_HEX;

   localparam logic       REG_RADIX_IDX = 1'b0;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [5:0] DIGIT_NONE = 6'd36;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } in_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      error;
   } out_item_type;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         digit_of = 6'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         digit_of = 6'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         digit_of = 6'(c - 8'h57);
      end else begin
         digit_of = DIGIT_NONE;
      end
   endfunction

   // bits per digit; zero when no radix is selected
   function automatic logic [2:0] radix_log(input logic [1:0] sel);
      unique case (sel)
         RADIX_BIN: radix_log = 3'd1;
         RADIX_OCT: radix_log = 3'd3;
         RADIX_HEX: radix_log = 3'd4;
         default:   radix_log = 3'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

[sv/rstoi_scan.sv]
//------------------------------------------------------------------------------
// rstoi_scan
// Per-character scan state and the end-of-string evaluation. Steps once per
// advanced item; on the last character gives the finished result and clears.
//------------------------------------------------------------------------------
`default_nettype none

module rstoi_scan #(
   parameter int MAX_CHARS = 10
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       step,
   input  rstoi_pkg::in_item_type    item,
   input  wire  [1:0]                radix_sel,
   output rstoi_pkg::out_item_type   result
);

   localparam int CNT_W = $clog2(MAX_CHARS + 2);
   localparam int ACC_W = rstoi_pkg::ACC_W;
   localparam int SUM_W = ACC_W + 4;
   localparam int V_W   = ACC_W + 1;
   localparam int VAL_W = rstoi_pkg::VALUE_W;

   localparam logic [1:0] PHASE_LEAD  = 2'd0;
   localparam logic [1:0] PHASE_TEXT  = 2'd1;
   localparam logic [1:0] PHASE_TRAIL = 2'd2;

   localparam logic [SUM_W-1:0] ACC_SAT = SUM_W'(1) << VAL_W;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sign_ff, sign_in;
   logic             minus_ff, minus_in;
   logic [3:0]       lead_ff, lead_in;
   logic [1:0]       phase_ff, phase_in;
   logic             bad_ff, bad_in;

   logic [2:0]       rlog;
   logic             radix_ok;
   logic             space_c;
   logic             sign_c;
   logic [5:0]       digit;
   logic             digit_ok;
   logic [SUM_W-1:0] sum;
   logic [ACC_W-1:0] acc_sat;
   logic [CNT_W-1:0] digits;
   logic [3:0]       half;
   logic [V_W-1:0]   modulus;
   logic             twos;
   logic             err_fmt;
   logic             err_rng;
   logic signed [V_W-1:0] v;

   always_comb begin
      rlog     = rstoi_pkg::radix_log(radix_sel);
      radix_ok = (rlog != 3'd0);
      space_c  = rstoi_pkg::is_space(item.char_code);
      sign_c   = (cnt_ff == '0) && (item.char_code == rstoi_pkg::CHAR_PLUS ||
                                    item.char_code == rstoi_pkg::CHAR_MINUS);
      digit    = rstoi_pkg::digit_of(item.char_code);
      digit_ok = radix_ok && (7'(digit) < (7'd1 << rlog));
      sum      = (SUM_W'(acc_ff) << rlog) + SUM_W'(digit);
      acc_sat  = (sum > ACC_SAT) ? ACC_W'(ACC_SAT) : sum[ACC_W-1:0];
   end

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      sign_in  = sign_ff;
      minus_in = minus_ff;
      lead_in  = lead_ff;
      phase_in = phase_ff;
      bad_in   = bad_ff;
      if (space_c) begin
         if (phase_ff == PHASE_TEXT) begin
            phase_in = PHASE_TRAIL;
         end
      end else begin
         if (phase_ff == PHASE_TRAIL) begin
            bad_in = 1'b1;
         end else begin
            phase_in = PHASE_TEXT;
         end
         if (cnt_ff <= CNT_W'(MAX_CHARS)) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (sign_c) begin
            sign_in  = 1'b1;
            minus_in = (item.char_code == rstoi_pkg::CHAR_MINUS);
         end else if (!digit_ok) begin
            bad_in = 1'b1;
         end else begin
            if (cnt_ff == CNT_W'(sign_ff)) begin
               lead_in = digit[3:0];
            end
            acc_in = acc_sat;
         end
      end
   end

   always_comb begin
      digits = cnt_in - CNT_W'(sign_in);
      unique case (radix_sel)
         rstoi_pkg::RADIX_BIN: begin
            half    = 4'd1;
            modulus = V_W'(1) << 10;
         end
         rstoi_pkg::RADIX_OCT: begin
            half    = 4'd4;
            modulus = V_W'(1) << 30;
         end
         rstoi_pkg::RADIX_HEX: begin
            half    = 4'd8;
            modulus = V_W'(1) << 40;
         end
         default: begin
            half    = 4'd0;
            modulus = '0;
         end
      endcase
      err_fmt = bad_in || !radix_ok || (cnt_in == '0) || (digits == '0) ||
                (cnt_in > CNT_W'(MAX_CHARS)) || acc_in[ACC_W-1];
      twos    = !minus_in && (int'(digits) == rstoi_pkg::TWOS_DIGITS) &&
                (lead_in >= half);
      if (minus_in) begin
         v = V_W'(0) - V_W'(acc_in);
      end else begin
         v = V_W'(acc_in) - (twos ? modulus : V_W'(0));
      end
      err_rng = !((v[V_W-1:VAL_W-1] == '0) || (v[V_W-1:VAL_W-1] == '1));
      result.error = err_fmt || err_rng;
      result.value = result.error ? '0 : v[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_char)) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         sign_ff  <= 1'b0;
         minus_ff <= 1'b0;
         lead_ff  <= '0;
         phase_ff <= PHASE_LEAD;
         bad_ff   <= 1'b0;
      end else if (step) begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         sign_ff  <= sign_in;
         minus_ff <= minus_in;
         lead_ff  <= lead_in;
         phase_ff <= phase_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

`default_nettype wire

[sv/radix_string_to_integer.sv]
//------------------------------------------------------------------------------
// radix_string_to_integer
// Parses a whitespace-trimmed, optionally signed binary, octal or hex string
// into a 40-bit signed integer, one character per item.
//------------------------------------------------------------------------------
// Takes one character per clock cycle while req_stall is low; req_stall rises
// while an item with last_char set waits for the result register. An item with
// last_char set presents one result through the input register, then the
// scan/evaluate logic into the result register; other items produce nothing.
// The scan state is updated once per character. The result register lets the
// next string start while a finished result waits on rsp_stall. Radix is set at
// register address 0 (reset: hexadecimal) and must only change while the block
// is idle. No clearing pass after reset.
//------------------------------------------------------------------------------
`default_nettype none

module radix_string_to_integer #(
   parameter int MAX_CHARS = 10
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  rstoi_pkg::in_item_type   req_item,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output rstoi_pkg::out_item_type  rsp_item,
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire  [2:0]               csr_paddr,
   input  wire  [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic                     radix_ff;
   logic [1:0]               radix_sel_ff;
   logic                     in_valid_ff;
   rstoi_pkg::in_item_type   in_item_ff;
   logic                     rsp_valid_ff;
   rstoi_pkg::out_item_type  rsp_item_ff;
   rstoi_pkg::out_item_type  result;
   logic                     out_free;
   logic                     advance;
   logic                     csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == rstoi_pkg::REG_RADIX_IDX);
   assign csr_prdata = csr_hit ? 32'(radix_sel_ff) : 32'(radix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_sel_ff <= rstoi_pkg::RADIX_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         radix_sel_ff <= csr_pwdata[1:0];
      end
   end

   // no other registers are mapped: unmapped reads return zero
   always_ff @(posedge clock) begin
      radix_ff <= 1'b0;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_item_ff.last_char || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_valid_ff || advance) begin
         in_item_ff <= req_item;
      end
   end

   rstoi_scan #(
      .MAX_CHARS (MAX_CHARS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .radix_sel (radix_sel_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_item_ff.last_char) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire
